// File: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared codes, state encoding and deadline compare for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_EXPIRE = 2'd2;

  localparam logic [2:0] KIND_INSERTED  = 3'd0;
  localparam logic [2:0] KIND_DROPPED   = 3'd1;
  localparam logic [2:0] KIND_REMOVED   = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_EXPIRED   = 3'd4;
  localparam logic [2:0] KIND_NONE_DUE  = 3'd5;

  localparam logic [20:0] ONE_SECOND_US = 21'd1000000;
  localparam logic [20:0] TWO_SECOND_US = 21'd2000000;

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_INS_START  = 10'b00_0000_0010,
    ST_INS_SCAN   = 10'b00_0000_0100,
    ST_INS_SHIFT  = 10'b00_0000_1000,
    ST_STOP_ISSUE = 10'b00_0001_0000,
    ST_STOP_SCAN  = 10'b00_0010_0000,
    ST_STOP_SHIFT = 10'b00_0100_0000,
    ST_EXP_ISSUE  = 10'b00_1000_0000,
    ST_EXP_EVAL   = 10'b01_0000_0000,
    ST_DONE       = 10'b10_0000_0000
  } state_t;

  // true when deadline a is strictly earlier than deadline b
  function automatic logic earlier(logic [33:0] a_sec, logic [19:0] a_usec,
                                   logic [33:0] b_sec, logic [19:0] b_usec);
    return (a_sec < b_sec) || ((a_sec == b_sec) && (a_usec < b_usec));
  endfunction

endpackage

// File: rtl/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Deadline-ordered timer queue held as a sorted ring in one synchronous RAM.
//
// Input channel (in_valid/in_stall) carries one command per transfer: start
// (now + delay, inserted in deadline order), stop (remove the first entry of
// a handler id) or expire (pop every entry strictly earlier than now). Unused
// command codes are consumed without a result.
// Output channel (out_valid/out_stall) carries one result per transfer; last
// marks the final result of a command. A start or stop gives one result, an
// expire gives one per popped entry, or a single "nothing due" result.
// One command is worked at a time; in_stall is high until its last result
// sits in the output register. The RAM walk reads and compares one entry per
// cycle unless a held output stalls it, and writes each entry it places or moves.
// A start scans from the head for its slot, then carries each later entry up.
// A held output stalls the walk only where a result must be written.
// Reset (rst, synchronous) empties the queue at once; the RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] now_sec,
  input  logic [19:0] now_usec,
  input  logic [31:0] delay_sec,
  input  logic [19:0] delay_usec,
  input  logic [7:0]  handler_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  expired_handler,
  output logic        last,
  output logic [4:0]  occupancy
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int XW  = AW + 1;
  localparam int IDW = (ID_BITS < 8) ? ID_BITS : 8;

  typedef struct packed {
    logic [32:0]    sec;
    logic [19:0]    usec;
    logic [IDW-1:0] id;
  } entry_t;

  stq_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   head, head_next;
  logic [AW-1:0]   idx, idx_next;

  logic [33:0]     new_sec;
  logic [19:0]     new_usec;
  logic [31:0]     now_s;
  logic [19:0]     now_u;
  logic [IDW-1:0]  hid;

  logic [2:0]      res_kind, res_kind_next;
  logic [IDW-1:0]  res_hid, res_hid_next;
  logic            pend_valid, pend_valid_next;
  logic [IDW-1:0]  pend_id, pend_id_next;
  logic [CW-1:0]   pend_occ, pend_occ_next;
  entry_t          carry, carry_next;

  logic            emit;
  logic [2:0]      emit_kind;
  logic [IDW-1:0]  emit_hid;
  logic            emit_last;
  logic [CW-1:0]   emit_occ;
  logic            out_free;

  entry_t          mem [DEPTH];
  logic            wr_en, rd_en;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;

  logic            accept;
  logic [20:0]     usec_sum;
  logic [19:0]     usec_fold;
  logic [1:0]      sec_carry;
  entry_t          new_entry;
  logic            e_before_new, new_before_e, due;
  logic [XW-1:0]   idx_x, count_x;

  // logical position in the ring to RAM address
  function automatic logic [AW-1:0] phys(logic [AW-1:0] base, logic [AW-1:0] lidx);
    logic [XW-1:0] s;
    s = {1'b0, base} + {1'b0, lidx};
    if (s >= XW'(DEPTH)) begin
      s = s - XW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign in_stall = (state != stq_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // deadline = now + delay, fold microseconds back below one second
  always_comb begin
    usec_sum = {1'b0, now_usec} + {1'b0, delay_usec};
    if (usec_sum >= stq_pkg::TWO_SECOND_US) begin
      usec_fold = 20'(usec_sum - stq_pkg::TWO_SECOND_US);
      sec_carry = 2'd2;
    end else if (usec_sum >= stq_pkg::ONE_SECOND_US) begin
      usec_fold = 20'(usec_sum - stq_pkg::ONE_SECOND_US);
      sec_carry = 2'd1;
    end else begin
      usec_fold = usec_sum[19:0];
      sec_carry = 2'd0;
    end
  end

  assign new_entry    = '{sec: new_sec[32:0], usec: new_usec, id: hid};
  assign e_before_new = stq_pkg::earlier({1'b0, rdata.sec}, rdata.usec, new_sec, new_usec);
  assign new_before_e = stq_pkg::earlier(new_sec, new_usec, {1'b0, rdata.sec}, rdata.usec);
  assign due          = (count != '0) &&
                        stq_pkg::earlier({1'b0, rdata.sec}, rdata.usec, {2'b00, now_s}, now_u);
  assign idx_x        = {1'b0, idx};
  assign count_x      = XW'(count);

  always_comb begin
    state_next      = state;
    count_next      = count;
    head_next       = head;
    idx_next        = idx;
    res_kind_next   = res_kind;
    res_hid_next    = res_hid;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    pend_occ_next   = pend_occ;
    carry_next      = carry;
    wr_en           = 1'b0;
    waddr           = '0;
    wdata           = new_entry;
    rd_en           = 1'b0;
    raddr           = '0;
    emit            = 1'b0;
    emit_kind       = res_kind;
    emit_hid        = res_hid;
    emit_last       = 1'b1;
    emit_occ        = count;

    unique case (state)
      stq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            stq_pkg::CMD_START:  state_next = stq_pkg::ST_INS_START;
            stq_pkg::CMD_STOP:   state_next = stq_pkg::ST_STOP_ISSUE;
            stq_pkg::CMD_EXPIRE: state_next = stq_pkg::ST_EXP_ISSUE;
            default:             state_next = stq_pkg::ST_IDLE;
          endcase
        end
      end

      stq_pkg::ST_INS_START: begin
        res_hid_next = '0;
        if (count_x == XW'(DEPTH)) begin
          res_kind_next = stq_pkg::KIND_DROPPED;
          state_next    = stq_pkg::ST_DONE;
        end else if (count == '0) begin
          wr_en         = 1'b1;
          waddr         = phys(head, '0);
          count_next    = count + 1'b1;
          res_kind_next = stq_pkg::KIND_INSERTED;
          state_next    = stq_pkg::ST_DONE;
        end else begin
          // walk forward from the head
          idx_next   = '0;
          rd_en      = 1'b1;
          raddr      = phys(head, '0);
          state_next = stq_pkg::ST_INS_SCAN;
        end
      end

      stq_pkg::ST_INS_SCAN: begin
        if ((idx == '0) ? new_before_e : !e_before_new) begin
          // place the new entry here and carry the old one up
          wr_en      = 1'b1;
          waddr      = phys(head, idx);
          carry_next = rdata;
          idx_next   = idx + 1'b1;
          if (idx_x + 1'b1 != count_x) begin
            rd_en = 1'b1;
            raddr = phys(head, idx + 1'b1);
          end
          state_next = stq_pkg::ST_INS_SHIFT;
        end else if (idx_x + 1'b1 == count_x) begin
          wr_en         = 1'b1;
          waddr         = phys(head, idx + 1'b1);
          count_next    = count + 1'b1;
          res_kind_next = stq_pkg::KIND_INSERTED;
          state_next    = stq_pkg::ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
          rd_en    = 1'b1;
          raddr    = phys(head, idx + 1'b1);
        end
      end

      stq_pkg::ST_INS_SHIFT: begin
        wr_en = 1'b1;
        waddr = phys(head, idx);
        wdata = carry;
        if (idx_x == count_x) begin
          count_next    = count + 1'b1;
          res_kind_next = stq_pkg::KIND_INSERTED;
          state_next    = stq_pkg::ST_DONE;
        end else begin
          carry_next = rdata;
          idx_next   = idx + 1'b1;
          if (idx_x + 1'b1 != count_x) begin
            rd_en = 1'b1;
            raddr = phys(head, idx + 1'b1);
          end
        end
      end

      stq_pkg::ST_STOP_ISSUE: begin
        res_hid_next = '0;
        idx_next     = '0;
        if (count == '0) begin
          res_kind_next = stq_pkg::KIND_NOT_FOUND;
          state_next    = stq_pkg::ST_DONE;
        end else begin
          rd_en      = 1'b1;
          raddr      = phys(head, '0);
          state_next = stq_pkg::ST_STOP_SCAN;
        end
      end

      stq_pkg::ST_STOP_SCAN: begin
        if (idx_x + 1'b1 != count_x) begin
          rd_en = 1'b1;
          raddr = phys(head, idx + 1'b1);
        end
        if (rdata.id == hid) begin
          res_kind_next = stq_pkg::KIND_REMOVED;
          res_hid_next  = hid;
          if (idx_x + 1'b1 == count_x) begin
            count_next = count - 1'b1;
            state_next = stq_pkg::ST_DONE;
          end else begin
            state_next = stq_pkg::ST_STOP_SHIFT;
          end
        end else if (idx_x + 1'b1 == count_x) begin
          res_kind_next = stq_pkg::KIND_NOT_FOUND;
          state_next    = stq_pkg::ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      stq_pkg::ST_STOP_SHIFT: begin
        // close the gap: entry idx+1 moves down to idx
        wr_en = 1'b1;
        waddr = phys(head, idx);
        wdata = rdata;
        if (idx_x + XW'(2) == count_x) begin
          count_next = count - 1'b1;
          state_next = stq_pkg::ST_DONE;
        end else begin
          rd_en    = 1'b1;
          raddr    = phys(head, AW'(idx_x + XW'(2)));
          idx_next = idx + 1'b1;
        end
      end

      stq_pkg::ST_EXP_ISSUE: begin
        pend_valid_next = 1'b0;
        rd_en           = 1'b1;
        raddr           = phys(head, '0);
        state_next      = stq_pkg::ST_EXP_EVAL;
      end

      stq_pkg::ST_EXP_EVAL: begin
        emit_kind = stq_pkg::KIND_EXPIRED;
        emit_hid  = pend_id;
        emit_occ  = pend_occ;
        if (due) begin
          // the held entry is not last: another one is due
          if (!pend_valid || out_free) begin
            emit            = pend_valid;
            emit_last       = 1'b0;
            pend_valid_next = 1'b1;
            pend_id_next    = rdata.id;
            pend_occ_next   = count - 1'b1;
            count_next      = count - 1'b1;
            head_next       = phys(head, AW'(1));
            rd_en           = 1'b1;
            raddr           = phys(head, AW'(1));
          end
        end else if (out_free) begin
          emit            = 1'b1;
          pend_valid_next = 1'b0;
          if (!pend_valid) begin
            emit_kind = stq_pkg::KIND_NONE_DUE;
            emit_hid  = '0;
            emit_occ  = count;
          end
          state_next = stq_pkg::ST_IDLE;
        end
      end

      stq_pkg::ST_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = stq_pkg::ST_IDLE;
        end
      end

      default: state_next = stq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stq_pkg::ST_IDLE;
      count      <= '0;
      head       <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      head       <= head_next;
      idx        <= idx_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_kind <= res_kind_next;
    res_hid  <= res_hid_next;
    pend_id  <= pend_id_next;
    pend_occ <= pend_occ_next;
    carry    <= carry_next;
    if (accept) begin
      new_sec  <= {2'b00, now_sec} + {2'b00, delay_sec} + 34'(sec_carry);
      new_usec <= usec_fold;
      now_s    <= now_sec;
      now_u    <= now_usec;
      hid      <= handler_id[IDW-1:0];
    end
  end

  // entry RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind            <= emit_kind;
      expired_handler <= 8'(emit_hid);
      last            <= emit_last;
      occupancy       <= 5'(emit_occ);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= XW'(DEPTH))
    else $error("entry count above depth");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (waddr != raddr))
    else $error("read and write hit the same entry");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + 1'b1) ||
    (count + 1'b1 == $past(count)))
    else $error("entry count moved by more than one");

  a_head_only_on_expire: assert property (@(posedge clk) disable iff (rst)
    (head != $past(head)) |-> ($past(state) == stq_pkg::ST_EXP_EVAL || $past(rst)))
    else $error("head moved outside expire");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result written over a held result");

endmodule

// File: sim/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_checker
// Watches both channels of the sorted timer queue, keeps its own copy of the
// timer entries, predicts every result of each accepted command and compares
// the results in order, field by field.
// ----------------------------------------------------------------------------
module stq_checker #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] now_sec,
  input  logic [19:0] now_usec,
  input  logic [31:0] delay_sec,
  input  logic [19:0] delay_usec,
  input  logic [7:0]  handler_id,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  expired_handler,
  input  logic        last,
  input  logic [4:0]  occupancy,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] hid;
    logic       last;
    logic [4:0] occ;
  } timer_result_t;

  logic [32:0]   timer_sec [DEPTH];
  logic [19:0]   timer_usec[DEPTH];
  logic [7:0]    timer_id  [DEPTH];
  int            timer_count = 0;
  timer_result_t due_results[$];
  timer_result_t want;
  int            mismatches = 0;

  // deadline a strictly ahead of deadline b
  function automatic logic runs_out_first(logic [33:0] a_s, logic [19:0] a_u,
                                          logic [33:0] b_s, logic [19:0] b_u);
    if (a_s != b_s) begin
      return a_s < b_s;
    end
    return a_u < b_u;
  endfunction

  task automatic post_result(input logic [2:0] k, input logic [7:0] h, input logic l);
    timer_result_t r;
    r = {k, h, l, timer_count[4:0]};
    due_results.push_back(r);
  endtask

  task automatic remove_timer(input int pos);
    int i;
    for (i = pos; i + 1 < timer_count; i++) begin
      timer_sec[i]  = timer_sec[i + 1];
      timer_usec[i] = timer_usec[i + 1];
      timer_id[i]   = timer_id[i + 1];
    end
    timer_count--;
  endtask

  task automatic apply_command(input logic [1:0] c, input logic [31:0] ns,
                               input logic [19:0] nu, input logic [31:0] dls,
                               input logic [19:0] dlu, input logic [7:0] id);
    logic [33:0]   ds;
    logic [20:0]   du;
    logic [7:0]    owner;
    int            pos;
    int            i;
    int            popped;
    logic          found;
    timer_result_t tail;
    case (c)
      stq_pkg::CMD_START: begin
        ds = {2'b00, ns} + {2'b00, dls};
        du = {1'b0, nu} + {1'b0, dlu};
        while (du >= stq_pkg::ONE_SECOND_US) begin
          du = du - stq_pkg::ONE_SECOND_US;
          ds = ds + 34'd1;
        end
        if (timer_count >= DEPTH) begin
          post_result(stq_pkg::KIND_DROPPED, 8'd0, 1'b1);
        end else begin
          if (timer_count == 0 ||
              runs_out_first(ds, du[19:0], {1'b0, timer_sec[0]}, timer_usec[0])) begin
            pos = 0;
          end else begin
            // past the head, land before any later entry with the same deadline
            pos = 1;
            while (pos < timer_count &&
                   runs_out_first({1'b0, timer_sec[pos]}, timer_usec[pos], ds, du[19:0]))
              pos++;
          end
          for (i = timer_count; i > pos; i--) begin
            timer_sec[i]  = timer_sec[i - 1];
            timer_usec[i] = timer_usec[i - 1];
            timer_id[i]   = timer_id[i - 1];
          end
          timer_sec[pos]  = ds[32:0];
          timer_usec[pos] = du[19:0];
          timer_id[pos]   = id;
          timer_count++;
          post_result(stq_pkg::KIND_INSERTED, 8'd0, 1'b1);
        end
      end
      stq_pkg::CMD_STOP: begin
        found = 1'b0;
        for (i = 0; i < timer_count && !found; i++) begin
          if (timer_id[i] == id) begin
            found = 1'b1;
            remove_timer(i);
            post_result(stq_pkg::KIND_REMOVED, id, 1'b1);
          end
        end
        if (!found) begin
          post_result(stq_pkg::KIND_NOT_FOUND, 8'd0, 1'b1);
        end
      end
      stq_pkg::CMD_EXPIRE: begin
        popped = 0;
        while (timer_count > 0 &&
               runs_out_first({1'b0, timer_sec[0]}, timer_usec[0], {2'b00, ns}, nu)) begin
          owner = timer_id[0];
          remove_timer(0);
          post_result(stq_pkg::KIND_EXPIRED, owner, 1'b0);
          popped++;
        end
        if (popped == 0) begin
          post_result(stq_pkg::KIND_NONE_DUE, 8'd0, 1'b1);
        end else begin
          tail = due_results.pop_back();
          tail.last = 1'b1;
          due_results.push_back(tail);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timer_count = 0;
      due_results.delete();
    end else begin
      // results first: a result at this edge never belongs to a command taken now
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: kind %0d handler %0d last %0d occupancy %0d",
                 kind, expired_handler, last, occupancy);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            mismatches++;
          end
          if (expired_handler !== want.hid) begin
            $error("expired_handler: expected %0d, got %0d", want.hid, expired_handler);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            mismatches++;
          end
          if (occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(cmd, now_sec, now_usec, delay_sec, delay_usec, handler_id);
      end
    end
    pending    <= due_results.size();
    fail_count <= mismatches;
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives start, stop and expire commands into the sorted timer queue: a
// directed run over the corner cases, then random command streams with
// random idling on both channels and one long output hold-off. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH          = 16;
  localparam int         RANDOM_ITEMS   = 195;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         HOLD_CYCLES    = 400;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd        = stq_pkg::CMD_EXPIRE;
  logic [31:0] now_sec    = '0;
  logic [19:0] now_usec   = '0;
  logic [31:0] delay_sec  = '0;
  logic [19:0] delay_usec = '0;
  logic [7:0]  handler_id = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  expired_handler;
  logic        last;
  logic [4:0]  occupancy;

  int   fail_count;
  int   pending;
  int   tx_idle_pct = 24;
  int   rx_idle_pct = 67;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;
  int   quiet       = 0;

  sorted_timer_queue #(.DEPTH(DEPTH), .ID_BITS(8)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .now_sec(now_sec), .now_usec(now_usec),
    .delay_sec(delay_sec), .delay_usec(delay_usec), .handler_id(handler_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .expired_handler(expired_handler), .last(last),
    .occupancy(occupancy)
  );

  stq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .now_sec(now_sec), .now_usec(now_usec),
    .delay_sec(delay_sec), .delay_usec(delay_usec), .handler_id(handler_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .expired_handler(expired_handler), .last(last),
    .occupancy(occupancy),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // offer one command and hold it until the transfer
  task automatic send_cmd(input logic [1:0] c, input logic [31:0] ns, input logic [19:0] nu,
                          input logic [31:0] dls, input logic [19:0] dlu,
                          input logic [7:0] id);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd        <= c;
    now_sec    <= ns;
    now_usec   <= nu;
    delay_sec  <= dls;
    delay_usec <= dlu;
    handler_id <= id;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [19:0] coarse_usec();
    if ($urandom_range(3) == 0) begin
      return 20'($urandom_range(999999));
    end
    return 20'($urandom_range(3) * 250000);
  endfunction

  initial begin
    int          i;
    int          r;
    int          seg_left;
    logic        filling;
    logic [31:0] t_sec;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue, ordering ties, carries, wrap, full, unused code
    send_cmd(stq_pkg::CMD_EXPIRE, 32'd0, 20'd0, 32'd0, 20'd0, 8'd0);
    send_cmd(stq_pkg::CMD_STOP, 32'd0, 20'd0, 32'd0, 20'd0, 8'd7);
    send_cmd(stq_pkg::CMD_START, 32'd10, 20'd0, 32'd0, 20'd0, 8'd3);
    send_cmd(stq_pkg::CMD_START, 32'd0, 20'd0, 32'd0, 20'd0, 8'd0);
    send_cmd(stq_pkg::CMD_START, 32'd0, 20'd0, 32'd0, 20'd0, 8'd1);
    send_cmd(stq_pkg::CMD_START, 32'd5, 20'hFFFFF, 32'd0, 20'hFFFFF, 8'd2);
    send_cmd(stq_pkg::CMD_START, 32'd7, 20'd97150, 32'd0, 20'd0, 8'd4);
    send_cmd(stq_pkg::CMD_START, 32'hFFFFFFFF, 20'd999999, 32'hFFFFFFFF, 20'd999999,
             8'd255);
    send_cmd(stq_pkg::CMD_START, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 8'd254);
    send_cmd(CMD_UNUSED, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 8'd255);
    send_cmd(stq_pkg::CMD_STOP, 32'd0, 20'd0, 32'd0, 20'd0, 8'd3);
    send_cmd(stq_pkg::CMD_STOP, 32'd0, 20'd0, 32'd0, 20'd0, 8'd3);
    for (i = 0; i < 10; i++) begin
      send_cmd(stq_pkg::CMD_START, 32'(8 + i), 20'(i * 1000), 32'd0, 20'd0, 8'(5 + i));
    end
    send_cmd(stq_pkg::CMD_START, 32'd1, 20'd0, 32'd0, 20'd0, 8'd99);
    send_cmd(stq_pkg::CMD_EXPIRE, 32'd7, 20'hFFFFF, 32'd0, 20'd0, 8'd0);
    send_cmd(stq_pkg::CMD_EXPIRE, 32'hFFFFFFFF, 20'hFFFFF, 32'd0, 20'd0, 8'd0);
    send_cmd(stq_pkg::CMD_STOP, 32'd0, 20'd0, 32'd0, 20'd0, 8'd255);
    send_cmd(stq_pkg::CMD_STOP, 32'd0, 20'd0, 32'd0, 20'd0, 8'd254);

    // random: fill and drain segments on a slowly advancing clock
    t_sec    = 32'($urandom_range(32'h7FFFFFFF));
    seg_left = 0;
    filling  = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        tx_idle_pct <= 67;
        rx_idle_pct <= 24;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      if (i == 60) begin
        hold_req <= 1'b1;
      end
      if (seg_left == 0) begin
        filling  = 1'($urandom_range(1));
        seg_left = $urandom_range(8, 30);
      end
      seg_left--;
      r = $urandom_range(99);
      if (r < 4) begin
        send_cmd(2'($urandom_range(3)), $urandom, 20'($urandom_range(20'hFFFFF)),
                 $urandom, 20'($urandom_range(20'hFFFFF)), 8'($urandom_range(255)));
      end else if (r < 6) begin
        send_cmd(CMD_UNUSED, $urandom, 20'($urandom_range(20'hFFFFF)),
                 $urandom, 20'($urandom_range(20'hFFFFF)), 8'($urandom_range(255)));
      end else if (r < (filling ? 80 : 36)) begin
        send_cmd(stq_pkg::CMD_START, t_sec, coarse_usec(), 32'($urandom_range(3)),
                 coarse_usec(), 8'($urandom_range(15)));
      end else if (r < (filling ? 88 : 56)) begin
        send_cmd(stq_pkg::CMD_STOP, t_sec, coarse_usec(), 32'd0, 20'd0,
                 8'($urandom_range(15)));
      end else begin
        t_sec = t_sec + 32'($urandom_range(2));
        send_cmd(stq_pkg::CMD_EXPIRE, t_sec, coarse_usec(), 32'd0, 20'd0, 8'd0);
      end
    end
    in_valid <= 1'b0;

    // drain, then let the block settle
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
